// ===== design/bdf_pkg.sv =====
// ----------------------------------------------------------------------------
// bdf_pkg
// Shared types and constants for the batched deadline two-queue scheduler.
// ----------------------------------------------------------------------------
package bdf_pkg;

   // Field widths.
   localparam int TAG_W   = 16;
   localparam int TIME_W  = 32;
   localparam int LIMIT_W = 8;
   localparam int EXP_W   = 16;
   localparam int CSR_W   = 16;
   localparam int IDX_W   = 2;

   // Packed channel widths; the data widths are rounded up to whole bytes.
   localparam int REQ_DATA_W = 48;   // req_tag, now
   localparam int REQ_USER_W = 2;    // func, is_sync
   localparam int RSP_DATA_W = 24;   // out_tag, out_sync, was_expired, zero fill
   localparam int RSP_USER_W = 2;    // status

   // Reset values of the control registers.
   localparam logic [LIMIT_W-1:0] BATCH_LIMIT_RST  = 8'd32;
   localparam logic [EXP_W-1:0]   SYNC_EXPIRY_RST  = 16'd125;
   localparam logic [EXP_W-1:0]   ASYNC_EXPIRY_RST = 16'd1250;

   // Operation codes carried in the request word.
   typedef enum logic {
      FN_ADD      = 1'b0,
      FN_DISPATCH = 1'b1
   } bdf_func_type;

   // Result status codes.
   typedef enum logic [1:0] {
      ST_ADDED      = 2'd0,
      ST_DISPATCHED = 2'd1,
      ST_EMPTY      = 2'd2,
      ST_FULL       = 2'd3
   } bdf_status_type;

   // Control register indexes.
   typedef enum logic [IDX_W-1:0] {
      REG_BATCH_LIMIT  = 2'd0,
      REG_SYNC_EXPIRY  = 2'd1,
      REG_ASYNC_EXPIRY = 2'd2
   } bdf_reg_type;

   // One queue entry.
   typedef struct packed {
      logic [TAG_W-1:0]  tag;
      logic [TIME_W-1:0] deadline;
   } bdf_entry_type;

   // Commands from the scheduler to one queue.
   typedef struct packed {
      logic              push;
      logic              pop;
      logic [TAG_W-1:0]  tag;
      logic [TIME_W-1:0] deadline;
   } bdf_qctl_type;

   // Status of one queue as seen by the scheduler.
   typedef struct packed {
      logic              empty;
      logic              full;
      logic [TAG_W-1:0]  head_tag;
      logic [TIME_W-1:0] head_deadline;
   } bdf_qstat_type;

endpackage

// ===== design/batched_deadline_two_fifo_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// batched_deadline_two_fifo_scheduler_core
// Two-class deadline scheduler: sync and async request queues, batched
// deadline checks on dispatch.
// ----------------------------------------------------------------------------
// The block takes one word per clock cycle while the result side is not
// stalled and returns exactly one result word for each, passing it through
// the request register first and then through the result register.
// The rate is set by the queue heads being held in registers that are
// refreshed from the queue memories in the same cycle that an item updates
// them, so adds and dispatches may follow each other in any mix. An add puts
// a tag with deadline now plus the class expiry into its queue, or reports
// the queue full. A dispatch serves the sync head, else the async head; once
// batch_limit dispatches have gone out, the next dispatch restarts the batch
// and first serves an expired sync head, then an expired async head.
// Deadlines compare with wrap-around of the 32-bit tick count. Control
// registers must be written while no word is in flight; not enforced here.
module batched_deadline_two_fifo_scheduler_core #(
   parameter int QUEUE_DEPTH = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   // Request channel.
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [bdf_pkg::REQ_DATA_W-1:0]     req_tdata,  // [15:0] req_tag, [47:16] now
   input  logic [bdf_pkg::REQ_USER_W-1:0]     req_tuser,  // [0] func, [1] is_sync
   // Result channel.
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [bdf_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // [15:0] out_tag, [16] out_sync,
                                                          // [17] was_expired, [23:18] zero
   output logic [bdf_pkg::RSP_USER_W-1:0]     rsp_tuser,  // [1:0] status
   // Control register write port.
   input  logic                               csr_wr_en,
   input  logic [bdf_pkg::IDX_W-1:0]          csr_index,
   input  logic [bdf_pkg::CSR_W-1:0]          csr_wdata
);
   import bdf_pkg::*;

   // Control registers.
   logic [LIMIT_W-1:0] batch_limit_ff;
   logic [EXP_W-1:0]   sync_expiry_ff;
   logic [EXP_W-1:0]   async_expiry_ff;

   // Request register.
   logic               item_valid_ff, item_valid_in;
   bdf_func_type       item_func_ff;
   logic               item_sync_ff;
   logic [TAG_W-1:0]   item_tag_ff;
   logic [TIME_W-1:0]  item_now_ff;

   // Result register.
   logic               rsp_valid_ff, rsp_valid_in;
   bdf_status_type     rsp_status_ff, rsp_status_in;
   logic [TAG_W-1:0]   rsp_tag_ff, rsp_tag_in;
   logic               rsp_sync_ff, rsp_sync_in;
   logic               rsp_exp_ff, rsp_exp_in;

   logic [LIMIT_W-1:0] batch_ff, batch_in;

   logic               advance;
   logic               fire;
   logic               req_take;

   bdf_qctl_type       sq_ctl, aq_ctl;
   bdf_qstat_type      sq_stat, aq_stat;

   logic               limit_hit;
   logic               sync_late, async_late;
   logic [TIME_W-1:0]  sync_gap, async_gap;
   logic [TIME_W-1:0]  deadline;
   logic [LIMIT_W-1:0] batch_base;

   // Handshake: the request register moves on whenever the result register
   // is free or being emptied.
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign fire       = item_valid_ff && advance;
   assign req_tready = !item_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      item_valid_in = item_valid_ff;
      if (req_take) begin
         item_valid_in = 1'b1;
      end else if (fire) begin
         item_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         batch_limit_ff  <= BATCH_LIMIT_RST;
         sync_expiry_ff  <= SYNC_EXPIRY_RST;
         async_expiry_ff <= ASYNC_EXPIRY_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_BATCH_LIMIT:  batch_limit_ff  <= csr_wdata[LIMIT_W-1:0];
            REG_SYNC_EXPIRY:  sync_expiry_ff  <= csr_wdata[EXP_W-1:0];
            REG_ASYNC_EXPIRY: async_expiry_ff <= csr_wdata[EXP_W-1:0];
            default: ;
         endcase
      end
   end

   // Head deadline checks, with wrap-around of the tick count.
   assign sync_gap   = item_now_ff - sq_stat.head_deadline;
   assign async_gap  = item_now_ff - aq_stat.head_deadline;
   assign sync_late  = !sq_stat.empty && !sync_gap[TIME_W-1];
   assign async_late = !aq_stat.empty && !async_gap[TIME_W-1];
   assign limit_hit  = (batch_ff >= batch_limit_ff);
   assign batch_base = limit_hit ? '0 : batch_ff;

   // Item decode: queue commands, batch counter and result fields.
   always_comb begin
      sq_ctl        = '0;
      aq_ctl        = '0;
      batch_in      = batch_ff;
      rsp_status_in = ST_EMPTY;
      rsp_tag_in    = '0;
      rsp_sync_in   = 1'b0;
      rsp_exp_in    = 1'b0;
      deadline      = item_now_ff +
                      TIME_W'(item_sync_ff ? sync_expiry_ff : async_expiry_ff);
      sq_ctl.tag      = item_tag_ff;
      sq_ctl.deadline = deadline;
      aq_ctl.tag      = item_tag_ff;
      aq_ctl.deadline = deadline;
      if (item_func_ff == FN_ADD) begin
         if (item_sync_ff) begin
            sq_ctl.push   = fire && !sq_stat.full;
            rsp_status_in = sq_stat.full ? ST_FULL : ST_ADDED;
         end else begin
            aq_ctl.push   = fire && !aq_stat.full;
            rsp_status_in = aq_stat.full ? ST_FULL : ST_ADDED;
         end
      end else begin
         if (fire) begin
            batch_in = batch_base;
         end
         priority if (limit_hit && sync_late) begin
            sq_ctl.pop    = fire;
            rsp_sync_in   = 1'b1;
            rsp_exp_in    = 1'b1;
            rsp_tag_in    = sq_stat.head_tag;
            rsp_status_in = ST_DISPATCHED;
         end else if (limit_hit && async_late) begin
            aq_ctl.pop    = fire;
            rsp_exp_in    = 1'b1;
            rsp_tag_in    = aq_stat.head_tag;
            rsp_status_in = ST_DISPATCHED;
         end else if (!sq_stat.empty) begin
            sq_ctl.pop    = fire;
            rsp_sync_in   = 1'b1;
            rsp_tag_in    = sq_stat.head_tag;
            rsp_status_in = ST_DISPATCHED;
         end else if (!aq_stat.empty) begin
            aq_ctl.pop    = fire;
            rsp_tag_in    = aq_stat.head_tag;
            rsp_status_in = ST_DISPATCHED;
         end else begin
            rsp_status_in = ST_EMPTY;
         end
         if (fire && (rsp_status_in == ST_DISPATCHED)) begin
            batch_in = batch_base + LIMIT_W'(1);
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         batch_ff      <= '0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         batch_ff      <= batch_in;
      end
   end

   // Request payload.
   always_ff @(posedge clock) begin
      if (req_take) begin
         item_func_ff <= bdf_func_type'(req_tuser[0]);
         item_sync_ff <= req_tuser[1];
         item_tag_ff  <= req_tdata[TAG_W-1:0];
         item_now_ff  <= req_tdata[TAG_W+TIME_W-1:TAG_W];
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_status_ff <= rsp_status_in;
         rsp_tag_ff    <= rsp_tag_in;
         rsp_sync_ff   <= rsp_sync_in;
         rsp_exp_ff    <= rsp_exp_in;
      end
   end

   bdf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_sync_queue (
      .clock (clock),
      .reset (reset),
      .ctl   (sq_ctl),
      .stat  (sq_stat)
   );

   bdf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_async_queue (
      .clock (clock),
      .reset (reset),
      .ctl   (aq_ctl),
      .stat  (aq_stat)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - TAG_W - 2){1'b0}}, rsp_exp_ff, rsp_sync_ff, rsp_tag_ff};

endmodule

// ===== design/bdf_queue.sv =====
// ----------------------------------------------------------------------------
// bdf_queue
// Circular request queue with a registered head entry, so that the head tag
// and deadline are ready at the start of every cycle.
// ----------------------------------------------------------------------------
module bdf_queue #(
   parameter int DEPTH = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  bdf_pkg::bdf_qctl_type ctl,
   output bdf_pkg::bdf_qstat_type stat
);
   import bdf_pkg::*;

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = CW + 1;

   logic [IW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;
   logic [IW-1:0] tail;
   logic [SW-1:0] tail_sum;

   bdf_entry_type mem_ff [DEPTH];
   bdf_entry_type rd_ff;
   bdf_entry_type byp_data_ff;
   logic          byp_ff;
   bdf_entry_type wr_entry;
   bdf_entry_type head_entry;

   // Tail slot is head plus count, wrapped once.
   always_comb begin
      tail_sum = SW'(head_ff) + SW'(count_ff);
      if (tail_sum >= SW'(DEPTH)) begin
         tail = IW'(tail_sum - SW'(DEPTH));
      end else begin
         tail = IW'(tail_sum);
      end
   end

   // Next head and count.
   always_comb begin
      head_in = head_ff;
      if (ctl.pop) begin
         if (head_ff == IW'(DEPTH - 1)) begin
            head_in = '0;
         end else begin
            head_in = head_ff + IW'(1);
         end
      end
      count_in = count_ff;
      if (ctl.push && !ctl.pop) begin
         count_in = count_ff + CW'(1);
      end else if (ctl.pop && !ctl.push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
         byp_ff   <= 1'b0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
         byp_ff   <= ctl.push && (tail == head_in);
      end
   end

   assign wr_entry.tag      = ctl.tag;
   assign wr_entry.deadline = ctl.deadline;

   // Storage: one write at the tail, one registered read at the next head.
   always_ff @(posedge clock) begin
      if (ctl.push) begin
         mem_ff[tail] <= wr_entry;
      end
      rd_ff <= mem_ff[head_in];
   end

   // A push into an empty queue lands on the slot being read; keep its copy.
   always_ff @(posedge clock) begin
      byp_data_ff <= wr_entry;
   end

   assign head_entry = byp_ff ? byp_data_ff : rd_ff;

   assign stat.empty         = (count_ff == '0);
   assign stat.full          = (count_ff == CW'(DEPTH));
   assign stat.head_tag      = head_entry.tag;
   assign stat.head_deadline = head_entry.deadline;

endmodule

// ===== design/bdf_checker.sv =====
// ----------------------------------------------------------------------------
// bdf_checker
// Port-level checks for the batched deadline two-queue scheduler.
// ----------------------------------------------------------------------------
module bdf_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [bdf_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [bdf_pkg::RSP_USER_W-1:0] rsp_tuser
);
   import bdf_pkg::*;

   // Reset empties the result register.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // A stalled result word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // Only a dispatch carries a tag, a class or an expiry mark.
   a_quiet_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != ST_DISPATCHED) |-> (rsp_tdata == '0))
      else $error("non-dispatch result with nonzero fields");

   // With the result side free the request side cannot be blocked.
   a_ready_when_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request side blocked while result side is free");

endmodule

bind batched_deadline_two_fifo_scheduler_core bdf_checker u_bdf_checker (.*);

// ===== tb/sv/batched_deadline_two_fifo_scheduler_core_tb.sv =====
// ----------------------------------------------------------------------------
// batched_deadline_two_fifo_scheduler_core_tb
// Self-checking bench for the two-class deadline request scheduler. A
// scoreboard that mirrors both request queues, the batch counter and the
// control registers predicts every result word. The scoreboard compares each
// returned word field by field; in most runs both stream sides pause at random.
// ----------------------------------------------------------------------------
module batched_deadline_two_fifo_scheduler_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bdf_pkg::*;

   localparam int QDEPTH      = 64;
   localparam int QIW         = $clog2(QDEPTH);
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_LIMIT = 5000;

   // Index past the end of the register list; writes to it must be dropped.
   localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;

   // One predicted result word.
   typedef struct {
      bdf_status_type    status;
      logic [TAG_W-1:0]  tag;
      logic              from_sync;
      logic              expired;
   } outcome_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // [15:0] req_tag, [47:16] now
   logic [REQ_USER_W-1:0] req_tuser = '0;   // [0] func, [1] is_sync
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // [15:0] out_tag, [16] out_sync,
                                            // [17] was_expired, [23:18] zero
   logic [RSP_USER_W-1:0] rsp_tuser;        // [1:0] status
   logic                  csr_wr_en = 1'b0;
   logic [IDX_W-1:0]      csr_index = '0;
   logic [CSR_W-1:0]      csr_wdata = '0;

   // Scheduler state as the scoreboard sees it.
   logic [TAG_W-1:0]   sq_tag [QDEPTH];
   logic [TIME_W-1:0]  sq_deadline [QDEPTH];
   logic [TAG_W-1:0]   aq_tag [QDEPTH];
   logic [TIME_W-1:0]  aq_deadline [QDEPTH];
   int                 sq_head, sq_count, aq_head, aq_count;
   logic [LIMIT_W-1:0] batch_count;
   logic [LIMIT_W-1:0] batch_limit;
   logic [EXP_W-1:0]   sync_expiry;
   logic [EXP_W-1:0]   async_expiry;

   outcome_type outcomes_due[$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int cycle_count = 0;
   int mismatch_count = 0;
   int words_checked = 0;
   int settings_used = 0;
   int n_added = 0, n_full = 0, n_dispatched = 0, n_expired = 0, n_empty = 0;
   logic [TIME_W-1:0] tick_now;

   batched_deadline_two_fifo_scheduler_core #(
      .QUEUE_DEPTH(QDEPTH)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Free-running clock, 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Run guard.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Run stopped after %0d cycles with %0d results outstanding",
                  cycle_count, outcomes_due.size());
         $display("Mismatches found");
         $finish;
      end
   end

   // The result side pauses at random.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   task automatic report_mismatch(string what, logic [TIME_W-1:0] want,
                                  logic [TIME_W-1:0] got);
      $display("ERROR word %0d, %s: expected 0x%0h, got 0x%0h",
               words_checked, what, want, got);
      mismatch_count++;
   endtask

   // Compare every accepted result word with the oldest prediction.
   always @(posedge clock) begin : check_results
      outcome_type due;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (outcomes_due.size() == 0) begin
            report_mismatch("word with no request pending", '0, TIME_W'(rsp_tdata));
         end else begin
            due = outcomes_due.pop_front();
            if (rsp_tuser != due.status)
               report_mismatch("status", TIME_W'(due.status), TIME_W'(rsp_tuser));
            if (rsp_tdata[15:0] != due.tag)
               report_mismatch("out_tag", TIME_W'(due.tag), TIME_W'(rsp_tdata[15:0]));
            if (rsp_tdata[16] != due.from_sync)
               report_mismatch("out_sync", TIME_W'(due.from_sync), TIME_W'(rsp_tdata[16]));
            if (rsp_tdata[17] != due.expired)
               report_mismatch("was_expired", TIME_W'(due.expired), TIME_W'(rsp_tdata[17]));
            if (rsp_tdata[23:18] != '0)
               report_mismatch("zero fill", '0, TIME_W'(rsp_tdata[23:18]));
         end
         words_checked++;
      end
   end

   task automatic clear_scoreboard();
      sq_head = 0;
      sq_count = 0;
      aq_head = 0;
      aq_count = 0;
      batch_count = '0;
      batch_limit = BATCH_LIMIT_RST;
      sync_expiry = SYNC_EXPIRY_RST;
      async_expiry = ASYNC_EXPIRY_RST;
   endtask

   // A head has expired when now is at or past its deadline, modulo 2^32.
   function automatic logic deadline_passed(logic [TIME_W-1:0] deadline,
                                            logic [TIME_W-1:0] now);
      logic [TIME_W-1:0] diff;
      diff = now - deadline;
      return ~diff[TIME_W-1];
   endfunction

   // Work out the result of one request word and advance the scoreboard.
   task automatic compute_outcome(bdf_func_type fn, logic is_sync,
                                  logic [TAG_W-1:0] tag, logic [TIME_W-1:0] now,
                                  output outcome_type res);
      int   slot;
      logic found;
      logic take_sync;
      res.status = ST_ADDED;
      res.tag = '0;
      res.from_sync = 1'b0;
      res.expired = 1'b0;
      found = 1'b0;
      take_sync = 1'b0;
      if (fn == FN_ADD) begin
         if (is_sync && sq_count >= QDEPTH) begin
            res.status = ST_FULL;
         end else if (is_sync) begin
            slot = (sq_head + sq_count) % QDEPTH;
            sq_tag[QIW'(slot)] = tag;
            sq_deadline[QIW'(slot)] = now + TIME_W'(sync_expiry);
            sq_count++;
         end else if (aq_count >= QDEPTH) begin
            res.status = ST_FULL;
         end else begin
            slot = (aq_head + aq_count) % QDEPTH;
            aq_tag[QIW'(slot)] = tag;
            aq_deadline[QIW'(slot)] = now + TIME_W'(async_expiry);
            aq_count++;
         end
         if (res.status == ST_FULL) n_full++;
         else n_added++;
      end else begin
         // A finished batch restarts and gives expired heads the first turn.
         if (batch_count >= batch_limit) begin
            batch_count = '0;
            if (sq_count != 0 && deadline_passed(sq_deadline[QIW'(sq_head)], now)) begin
               found = 1'b1;
               take_sync = 1'b1;
               res.expired = 1'b1;
            end else if (aq_count != 0 &&
                         deadline_passed(aq_deadline[QIW'(aq_head)], now)) begin
               found = 1'b1;
               res.expired = 1'b1;
            end
         end
         if (!found) begin
            if (sq_count != 0) begin
               found = 1'b1;
               take_sync = 1'b1;
            end else if (aq_count != 0) begin
               found = 1'b1;
            end
         end
         if (found && take_sync) begin
            res.tag = sq_tag[QIW'(sq_head)];
            sq_head = (sq_head + 1) % QDEPTH;
            sq_count--;
         end else if (found) begin
            res.tag = aq_tag[QIW'(aq_head)];
            aq_head = (aq_head + 1) % QDEPTH;
            aq_count--;
         end
         if (found) begin
            res.status = ST_DISPATCHED;
            res.from_sync = take_sync;
            batch_count = batch_count + LIMIT_W'(1);
            n_dispatched++;
            if (res.expired) n_expired++;
         end else begin
            res.status = ST_EMPTY;
            n_empty++;
         end
      end
   endtask

   // Send one request word; returns in the step where it was accepted.
   task automatic send_word(bdf_func_type fn, logic is_sync, logic [TAG_W-1:0] tag,
                            logic [TIME_W-1:0] now);
      outcome_type due;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {now, tag};
      req_tuser <= {is_sync, fn};
      compute_outcome(fn, is_sync, tag, now, due);
      outcomes_due.push_back(due);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Stop sending and wait for every predicted word to come back.
   task automatic drain_results();
      int waited;
      waited = 0;
      req_tvalid <= 1'b0;
      while (outcomes_due.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
   endtask

   task automatic write_reg(logic [IDX_W-1:0] idx, logic [CSR_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         REG_BATCH_LIMIT:  batch_limit = value[LIMIT_W-1:0];
         REG_SYNC_EXPIRY:  sync_expiry = value[EXP_W-1:0];
         REG_ASYNC_EXPIRY: async_expiry = value[EXP_W-1:0];
         default: ;
      endcase
   endtask

   // Load all three registers, then poke the unused index. The block is idle.
   task automatic set_config(logic [LIMIT_W-1:0] limit, logic [EXP_W-1:0] s_exp,
                             logic [EXP_W-1:0] a_exp);
      logic [7:0] upper;
      upper = 8'($urandom_range(0, 255));
      write_reg(REG_BATCH_LIMIT, {upper, limit});
      write_reg(REG_SYNC_EXPIRY, s_exp);
      write_reg(REG_ASYNC_EXPIRY, a_exp);
      write_reg(REG_UNUSED, CSR_W'($urandom_range(0, 65535)));
      csr_wr_en <= 1'b0;
      settings_used++;
   endtask

   task automatic set_idle(int send_pct, int recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
   endtask

   // Reset settings: empty queues, both classes, extreme tags and times.
   task automatic test_directed_basic();
      send_word(FN_DISPATCH, 1'b1, 16'hFFFF, 32'h0000_0000);
      send_word(FN_ADD, 1'b1, 16'h0000, 32'h0000_0000);
      send_word(FN_ADD, 1'b1, 16'hFFFF, 32'hFFFF_FFFF);
      send_word(FN_ADD, 1'b0, 16'h8001, 32'h8000_0000);
      send_word(FN_ADD, 1'b0, 16'h7FFE, 32'h7FFF_FFFF);
      send_word(FN_DISPATCH, 1'b0, 16'h0000, 32'h0000_0010);
      send_word(FN_DISPATCH, 1'b1, 16'h1234, 32'h0000_0020);
      send_word(FN_DISPATCH, 1'b0, 16'h0000, 32'h0000_0030);
      send_word(FN_DISPATCH, 1'b0, 16'h0000, 32'h0000_0040);
      send_word(FN_DISPATCH, 1'b1, 16'hFFFF, 32'hFFFF_FFFF);
      drain_results();
   endtask

   // Batch limit of one, lowered under the running count: an expired async
   // head must overtake a live sync head, deadlines wrap past zero.
   task automatic test_directed_expiry_order();
      logic [TIME_W-1:0] t0;
      t0 = 32'hFFFF_FFF0;
      set_config(8'd1, 16'hFFFF, 16'd1);
      send_word(FN_ADD, 1'b1, 16'h1111, t0);
      send_word(FN_ADD, 1'b1, 16'h2222, t0);
      send_word(FN_ADD, 1'b0, 16'h3333, t0);
      send_word(FN_DISPATCH, 1'b0, 16'h0000, t0 + 32'd5);
      send_word(FN_DISPATCH, 1'b0, 16'h0000, t0 + 32'd5);
      send_word(FN_DISPATCH, 1'b0, 16'h0000, t0 + 32'd20);
      send_word(FN_ADD, 1'b1, 16'h4444, t0);
      send_word(FN_DISPATCH, 1'b1, 16'h0000, t0 + 32'd70000);
      drain_results();
   endtask

   // Zero limit and zero expiry: every dispatch checks deadlines and every
   // request is due the moment it is added.
   task automatic test_directed_zero_settings();
      set_config(8'd0, 16'd0, 16'd0);
      send_word(FN_ADD, 1'b0, 16'h5A5A, 32'h1234_5678);
      send_word(FN_ADD, 1'b1, 16'hA5A5, 32'h1234_5678);
      send_word(FN_DISPATCH, 1'b0, 16'h0000, 32'h1234_5678);
      send_word(FN_DISPATCH, 1'b0, 16'h0000, 32'h1234_5678);
      send_word(FN_DISPATCH, 1'b0, 16'h0000, 32'h1234_5678);
      drain_results();
   endtask

   // Random traffic with a tick count that mostly creeps forward and now and
   // then jumps, so deadlines expire, wrap and stay pending in turn.
   task automatic test_random_traffic(logic [LIMIT_W-1:0] limit, logic [EXP_W-1:0] s_exp,
                                      logic [EXP_W-1:0] a_exp, int items, int add_pct,
                                      int step_max, logic [TIME_W-1:0] start_tick);
      bdf_func_type fn;
      set_config(limit, s_exp, a_exp);
      tick_now = start_tick;
      for (int i = 0; i < items; i++) begin
         if ($urandom_range(0, 99) < 3) tick_now = $urandom();
         else tick_now = tick_now + $urandom_range(0, step_max);
         fn = ($urandom_range(0, 99) < add_pct) ? FN_ADD : FN_DISPATCH;
         send_word(fn, 1'($urandom_range(0, 1)), TAG_W'($urandom_range(0, 65535)),
                   tick_now);
      end
      drain_results();
   endtask

   initial begin
      clear_scoreboard();
      set_idle(30, 85);
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_basic();
      test_directed_expiry_order();
      test_directed_zero_settings();

      test_random_traffic(8'd32, 16'd125, 16'd1250, 300, 75, 8, $urandom());
      test_random_traffic(8'd1, 16'd1, 16'hFFFF, 250, 35, 30, $urandom());
      set_idle(85, 30);
      test_random_traffic(8'd255, 16'hFFFF, 16'd1, 300, 55, 50, 32'hFFFF_F000);
      test_random_traffic(8'd0, 16'd0, 16'd0, 200, 50, 5, $urandom());
      set_idle(0, 0);
      test_random_traffic(LIMIT_W'($urandom_range(1, 255)), EXP_W'($urandom_range(1, 65535)),
                          EXP_W'($urandom_range(1, 65535)), 300, 65, 20, $urandom());
      test_random_traffic(8'd3, 16'd40, 16'd300, 250, 45, 10, $urandom());
      test_random_traffic(LIMIT_W'($urandom_range(1, 255)), EXP_W'($urandom_range(1, 65535)),
                          EXP_W'($urandom_range(1, 65535)), 250, 50, 100, 32'h7FFF_FF00);

      // Let the pipeline settle so stray words are caught.
      drain_results();
      repeat (8) @(posedge clock);
      if (outcomes_due.size() != 0)
         report_mismatch("words never returned", '0, outcomes_due.size());

      $display("Requests: %0d added, %0d refused on a full queue, %0d dispatched",
               n_added, n_full, n_dispatched);
      $display("Dispatches past deadline %0d, on empty queues %0d; %0d words checked, %0d settings",
               n_expired, n_empty, words_checked, settings_used);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
